### hw/rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Shared constants, codes and types of the slot allocator and its free queue.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int FREE_DEPTH = 64;

    localparam int SLOT_W  = 10;
    localparam int FRESH_W = 11;
    localparam int CNT_W   = $clog2(FREE_DEPTH + 1);
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int DATA_W  = 16;

    localparam logic [FRESH_W-1:0] SLOT_LIMIT = FRESH_W'(MAX_SLOTS);
    localparam logic [CNT_W-1:0]   QUEUE_FULL = CNT_W'(FREE_DEPTH);

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Store and view kinds
    localparam logic [KIND_W-1:0] KIND_SHADER_RES    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RENDER_TGT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEPTH_STENCIL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SAMPLER       = 2'd3;
    localparam logic [KIND_W-1:0] KIND_INVALID       = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_KIND      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_START = 2'd2;

    typedef enum logic [2:0] {
        STS_ALLOCATED  = 3'd0,
        STS_WRONG_KIND = 3'd1,
        STS_FULL       = 3'd2,
        STS_FREED      = 3'd3,
        STS_DUPLICATE  = 3'd4,
        STS_QUEUE_FULL = 3'd5
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Per-cell control from the queue to each cell.
    typedef struct packed {
        logic occupied;
        logic load;
        logic shift;
        logic sample;
    } cell_ctl_t;

endpackage

### hw/rtl/dsa_cell.sv
// ----------------------------------------------------------------------------
// Free queue cell
// Holds one queued slot, shifts towards the head on a dequeue, loads a new
// slot when it is the tail, and registers whether it holds a probed slot.
// ----------------------------------------------------------------------------
module dsa_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dsa_pkg::cell_ctl_t          ctl,
    input  logic [dsa_pkg::SLOT_W-1:0]  wr_slot,
    input  logic [dsa_pkg::SLOT_W-1:0]  nbr_slot,
    input  logic [dsa_pkg::SLOT_W-1:0]  probe_slot,
    output logic [dsa_pkg::SLOT_W-1:0]  slot,
    output logic                        match
);
    import dsa_pkg::*;

    logic [SLOT_W-1:0] slot_reg;
    logic              match_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            slot_reg <= wr_slot;
        end
        else if (ctl.shift)
        begin
            slot_reg <= nbr_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.sample)
        begin
            match_reg <= ctl.occupied && (slot_reg == probe_slot);
        end
    end

    assign slot  = slot_reg;
    assign match = match_reg;

endmodule

### hw/rtl/dsa_queue.sv
// ----------------------------------------------------------------------------
// Free queue cell chain
// A row of cells kept in age order, the oldest slot in cell zero. The fill
// count selects the tail cell and marks which cells hold a queued slot.
// ----------------------------------------------------------------------------
module dsa_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [dsa_pkg::CNT_W-1:0]   count,
    input  logic                        enqueue,
    input  logic                        dequeue,
    input  logic                        sample,
    input  logic [dsa_pkg::SLOT_W-1:0]  probe_slot,
    input  logic [dsa_pkg::SLOT_W-1:0]  wr_slot,
    output logic [dsa_pkg::SLOT_W-1:0]  head_slot,
    output logic                        duplicate
);
    import dsa_pkg::*;

    logic [SLOT_W-1:0]     slots [FREE_DEPTH];
    logic [FREE_DEPTH-1:0] hit_vec;

    for (genvar i = 0; i < FREE_DEPTH; i++)
    begin : g_cell
        cell_ctl_t         ctl;
        logic [SLOT_W-1:0] nbr;

        assign ctl.occupied = count > CNT_W'(i);
        assign ctl.load     = enqueue && (count == CNT_W'(i));
        assign ctl.shift    = dequeue;
        assign ctl.sample   = sample;

        if (i == FREE_DEPTH - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = slots[i+1];
        end

        dsa_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .wr_slot    (wr_slot),
            .nbr_slot   (nbr),
            .probe_slot (probe_slot),
            .slot       (slots[i]),
            .match      (hit_vec[i])
        );
    end

    assign head_slot = slots[0];
    assign duplicate = |hit_vec;

endmodule

### hw/rtl/descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator
// Allocates and releases slot numbers of a descriptor store through a
// first-in first-out free queue and a fresh-slot counter.
// ----------------------------------------------------------------------------
// Each request is handled as follows: in the cycle of the transfer every
// free-queue cell compares its slot with the request's slot and registers the
// outcome, and in the next cycle the combined match, the queue fill count and
// the fresh-slot counter decide the result, which goes to an output register.
// A new request is taken once the previous result has left or leaves in the
// same cycle, and never while one is still being decided, so requests do not
// overlap. The free queue needs no clearing after reset.
// Configuration writes belong to idle periods; writing the store kind or the
// reserved start reloads the fresh-slot counter and keeps the queue.
module descriptor_slot_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsa_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dsa_pkg::DATA_W-1:0]      s_tdata,  // op, view_kind[1:0], slot_index[9:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dsa_pkg::DATA_W-1:0]      m_tdata   // status[2:0], granted_slot[9:0]
);
    import dsa_pkg::*;

    state_t state_reg, state_next;

    logic [KIND_W-1:0]  heap_kind_reg;
    logic [CFG_W-1:0]   capacity_reg;
    logic [CFG_W-1:0]   reserved_start_reg;
    logic [FRESH_W-1:0] next_fresh_reg;
    logic [CNT_W-1:0]   free_count_reg;

    logic               op_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [SLOT_W-1:0]  slot_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [SLOT_W-1:0]  out_slot_reg;

    logic               accept;
    logic               exec_en;
    logic [FRESH_W-1:0] limit;
    logic               wrong_kind;
    logic               enqueue;
    logic               dequeue;
    logic               fresh_take;
    logic [SLOT_W-1:0]  head_slot;
    logic               duplicate;
    status_t            res_status;
    logic [SLOT_W-1:0]  res_slot;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready = 1'b0;
        exec_en  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = !out_valid_reg || m_tready;
            end
            ST_EXEC:
            begin
                exec_en = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Request decision
    assign limit      = (capacity_reg > SLOT_LIMIT) ? SLOT_LIMIT : capacity_reg;
    assign wrong_kind = (kind_reg == KIND_INVALID) || (kind_reg != heap_kind_reg);

    always_comb
    begin
        res_status = STS_FULL;
        res_slot   = '0;
        enqueue    = 1'b0;
        dequeue    = 1'b0;
        fresh_take = 1'b0;
        if (op_reg == OP_ALLOC)
        begin
            if (wrong_kind)
            begin
                res_status = STS_WRONG_KIND;
            end
            else if (free_count_reg != '0)
            begin
                res_status = STS_ALLOCATED;
                res_slot   = head_slot;
                dequeue    = exec_en;
            end
            else if (next_fresh_reg < limit)
            begin
                res_status = STS_ALLOCATED;
                res_slot   = next_fresh_reg[SLOT_W-1:0];
                fresh_take = exec_en;
            end
            else
            begin
                res_status = STS_FULL;
            end
        end
        else
        begin
            if (duplicate)
            begin
                res_status = STS_DUPLICATE;
            end
            else if (free_count_reg >= QUEUE_FULL)
            begin
                res_status = STS_QUEUE_FULL;
            end
            else
            begin
                res_status = STS_FREED;
                enqueue    = exec_en;
            end
        end
    end

    dsa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .count      (free_count_reg),
        .enqueue    (enqueue),
        .dequeue    (dequeue),
        .sample     (accept),
        .probe_slot (s_tdata[12:3]),
        .wr_slot    (slot_reg),
        .head_slot  (head_slot),
        .duplicate  (duplicate)
    );

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tdata[0];
            kind_reg <= s_tdata[2:1];
            slot_reg <= s_tdata[12:3];
        end
    end

    // Configuration, fresh-slot counter and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_kind_reg      <= KIND_SHADER_RES;
            capacity_reg       <= CFG_W'(MAX_SLOTS);
            reserved_start_reg <= '0;
            next_fresh_reg     <= '0;
            free_count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HEAP_KIND:
                    begin
                        heap_kind_reg  <= cfg_data[KIND_W-1:0];
                        next_fresh_reg <= (cfg_data[KIND_W-1:0] == KIND_SHADER_RES)
                                          ? reserved_start_reg : '0;
                    end
                    REG_CAPACITY:
                    begin
                        capacity_reg <= cfg_data;
                    end
                    REG_RESERVED_START:
                    begin
                        reserved_start_reg <= cfg_data;
                        next_fresh_reg     <= (heap_kind_reg == KIND_SHADER_RES)
                                              ? cfg_data : '0;
                    end
                    default:
                    begin
                        heap_kind_reg <= heap_kind_reg;
                    end
                endcase
            end
            else if (fresh_take)
            begin
                next_fresh_reg <= FRESH_W'(next_fresh_reg + FRESH_W'(1));
            end

            if (enqueue)
            begin
                free_count_reg <= CNT_W'(free_count_reg + CNT_W'(1));
            end
            else if (dequeue)
            begin
                free_count_reg <= CNT_W'(free_count_reg - CNT_W'(1));
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_slot_reg, out_status_reg};

endmodule
